// ----- rtl/md5_pkg.sv -----
`timescale 1ns / 1ps
// MD5 core package: item structs, initial chaining values and round tables.
// No dependencies; imported by md5_message_digest_core.
package md5_pkg;

  // input item: one message byte plus end marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } md5_in_t;

  // result item: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [2:0] LEN_SLOT = 3'd7;  // byte positions 56..63

  // additive round constant
  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // left rotate amount, selected by phase and round within group of four
  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/md5_message_digest_core.sv -----
`timescale 1ns / 1ps
// MD5 core: byte-stream digest with one shared round datapath.
// Sequence: a byte that does not fill the block is taken while the core stays idle; a byte
// that fills it starts 64 rounds of the shared round unit, one per cycle, then a fold.
// A last item then adds a pad state, a length state and a final block, plus an extra
// block when the pad byte lands in bytes 56..63; then four digest items.
// Ready is low meanwhile. Reset (rst_n synchronous) loads the initial chaining words and zeroes the count.
module md5_message_digest_core
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  md5_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output md5_out_t out_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  // where to go after a block is folded in
  localparam logic [1:0] POST_IDLE = 2'd0;
  localparam logic [1:0] POST_PAD  = 2'd1;
  localparam logic [1:0] POST_LEN  = 2'd2;
  localparam logic [1:0] POST_EMIT = 2'd3;

  logic [2:0]  state_r;
  logic [1:0]  post_r;
  logic [5:0]  round_r;
  logic [1:0]  idx_r;
  logic        extra_r;
  logic [60:0] count_r;
  logic [31:0] chain_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] buf_r [16];

  logic        in_fire;
  logic        out_fire;
  logic [5:0]  pos;
  logic [31:0] len_lo, len_hi;

  // round unit
  logic [1:0]  phase;
  logic [3:0]  r4;
  logic [3:0]  g;
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_wide;
  logic [31:0] b_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (state_r == S_EMIT);
  assign out_fire  = out_valid && out_ready;
  assign pos = count_r[5:0];

  // bit length, little-endian words 14 and 15
  assign len_lo = {count_r[28:0], 3'b000};
  assign len_hi = count_r[60:29];

  assign out_data.digest_word = chain_r[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == 2'd3);

  // one MD5 round
  always_comb begin
    phase = round_r[5:4];
    r4    = round_r[3:0];
    case (phase)
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g = r4;
      end
      2'd1: begin
        f = (b_r & d_r) | (c_r & ~d_r);
        g = r4 + {r4[1:0], 2'b00} + 4'd1;
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g = r4 + {r4[2:0], 1'b0} + 4'd5;
      end
      2'd3: begin
        f = c_r ^ (b_r | ~d_r);
        g = {r4[0], 3'b000} - r4;
      end
      default: begin
        f = 32'h0;
        g = 4'd0;
      end
    endcase
    sum      = a_r + f + buf_r[g] + round_const(round_r);
    rot_wide = {sum, sum} << rot_amount({phase, round_r[1:0]});
    b_nxt    = b_r + rot_wide[63:32];
  end

  // sequencer, count and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      post_r     <= POST_IDLE;
      round_r    <= 6'd0;
      idx_r      <= 2'd0;
      extra_r    <= 1'b0;
      count_r    <= '0;
      chain_r[0] <= INIT_A;
      chain_r[1] <= INIT_B;
      chain_r[2] <= INIT_C;
      chain_r[3] <= INIT_D;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.byte_valid) begin
              count_r <= count_r + 61'd1;
              if (pos == 6'd63) begin
                state_r <= S_ROUND;
                round_r <= 6'd0;
                post_r  <= in_data.last ? POST_PAD : POST_IDLE;
              end else if (in_data.last) begin
                state_r <= S_PAD;
              end
            end else if (in_data.last) begin
              state_r <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          round_r <= round_r + 6'd1;
          if (round_r == 6'd63) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          case (post_r)
            POST_IDLE: state_r <= S_IDLE;
            POST_PAD:  state_r <= S_PAD;
            POST_LEN:  state_r <= S_LEN;
            POST_EMIT: begin
              state_r <= S_EMIT;
              idx_r   <= 2'd0;
            end
            default:   state_r <= S_IDLE;
          endcase
        end
        S_PAD: begin
          // length does not fit after the pad byte: one extra block first
          if (pos[5:3] == LEN_SLOT) begin
            extra_r <= 1'b1;
            state_r <= S_ROUND;
            round_r <= 6'd0;
            post_r  <= POST_LEN;
          end else begin
            extra_r <= 1'b0;
            state_r <= S_LEN;
          end
        end
        S_LEN: begin
          state_r <= S_ROUND;
          round_r <= 6'd0;
          post_r  <= POST_EMIT;
        end
        S_EMIT: begin
          if (out_fire) begin
            idx_r <= idx_r + 2'd1;
            if (idx_r == 2'd3) begin
              state_r    <= S_IDLE;
              count_r    <= '0;
              chain_r[0] <= INIT_A;
              chain_r[1] <= INIT_B;
              chain_r[2] <= INIT_C;
              chain_r[3] <= INIT_D;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // working registers of the round unit
  always_ff @(posedge clk) begin
    if (state_r == S_ROUND) begin
      a_r <= d_r;
      b_r <= b_nxt;
      c_r <= b_r;
      d_r <= c_r;
    end else begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end
  end

  // block buffer: message bytes, padding and length
  always_ff @(posedge clk) begin
    logic [5:0] bi;
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 4; j++) begin
        bi = 6'(i * 4 + j);
        if (in_fire && in_data.byte_valid && (bi == pos)) begin
          buf_r[i][8*j +: 8] <= in_data.data_byte;
        end else if (state_r == S_PAD) begin
          if (bi == pos) begin
            buf_r[i][8*j +: 8] <= PAD_BYTE;
          end else if (bi > pos) begin
            buf_r[i][8*j +: 8] <= 8'h00;
          end
        end else if ((state_r == S_LEN) && extra_r && (i < 14)) begin
          buf_r[i][8*j +: 8] <= 8'h00;
        end
      end
    end
    if (state_r == S_LEN) begin
      buf_r[14] <= len_lo;
      buf_r[15] <= len_hi;
    end
  end

endmodule
